// File: src/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg: primitive assembly shared definitions
// Mode codes, primitive kinds, the primitive record and common widths.
// ----------------------------------------------------------------------------
package pa_pkg;

    // width of a corner field on the ports
    localparam int FIELD_W = 32;
    // default width of the vertex index that is actually kept
    localparam int INDEX_WIDTH_DEF = 32;
    localparam int MODE_W = 4;

    // GL primitive modes
    typedef enum logic [MODE_W-1:0] {
        MODE_POINTS         = 4'd0,
        MODE_LINES          = 4'd1,
        MODE_LINE_LOOP      = 4'd2,
        MODE_LINE_STRIP     = 4'd3,
        MODE_TRIANGLES      = 4'd4,
        MODE_TRIANGLE_STRIP = 4'd5,
        MODE_TRIANGLE_FAN   = 4'd6,
        MODE_QUADS          = 4'd7,
        MODE_QUAD_STRIP     = 4'd8,
        MODE_POLYGON        = 4'd9
    } mode_t;

    localparam mode_t MODE_RESET = MODE_TRIANGLES;

    // kind of an emitted primitive
    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_TRIANGLE = 2'd2
    } kind_t;

    // one emitted primitive
    typedef struct packed {
        logic               run_last;
        kind_t              prim_kind;
        logic [FIELD_W-1:0] corner_c;
        logic [FIELD_W-1:0] corner_b;
        logic [FIELD_W-1:0] corner_a;
    } prim_t;

    // status of the result queue towards the assembler side
    typedef struct packed {
        logic       room;
        logic [1:0] level;
    } q_status_t;

endpackage

// File: src/pa_assemble.sv
// ----------------------------------------------------------------------------
// pa_assemble: vertex history and primitive selection
// Holds the mode register and vertex history, and forms up to two
// primitives from each accepted item in a single combinational pass.
// ----------------------------------------------------------------------------
module pa_assemble
    import pa_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [MODE_W-1:0]  cfg_wdata,
    input  logic               item_acc,
    input  logic [FIELD_W-1:0] vertex_index,
    input  logic               set_last,
    output logic [1:0]         prim_count,
    output prim_t              prim0,
    output prim_t              prim1
);

    logic [MODE_W-1:0]      mode_reg;
    logic [INDEX_WIDTH-1:0] anchor_reg, anchor_next;
    logic [INDEX_WIDTH-1:0] older_reg;
    logic [INDEX_WIDTH-1:0] newer_reg;
    logic [1:0]             phase_reg, phase_next;
    logic [1:0]             fill_reg, fill_next;

    logic [INDEX_WIDTH-1:0] v;
    logic [FIELD_W-1:0]     v_x, anchor_x, older_x, newer_x;
    logic                   quad_mode;

    assign v        = vertex_index[INDEX_WIDTH-1:0];
    assign v_x      = FIELD_W'(v);
    assign anchor_x = FIELD_W'(anchor_reg);
    assign older_x  = FIELD_W'(older_reg);
    assign newer_x  = FIELD_W'(newer_reg);
    assign quad_mode = (mode_reg == MODE_QUADS) || (mode_reg == MODE_QUAD_STRIP);

    // primitive selection per mode
    always_comb begin
        prim0 = '0;
        prim1 = '0;
        prim_count = 2'd0;
        unique case (mode_reg) inside
            MODE_POINTS: begin
                prim0.prim_kind = KIND_POINT;
                prim0.corner_a  = v_x;
                prim_count      = 2'd1;
            end
            MODE_LINES: begin
                if (phase_reg[0]) begin
                    prim0.prim_kind = KIND_LINE;
                    prim0.corner_a  = newer_x;
                    prim0.corner_b  = v_x;
                    prim_count      = 2'd1;
                end
            end
            MODE_LINE_LOOP: begin
                if (fill_reg != 2'd0) begin
                    prim0.prim_kind = KIND_LINE;
                    prim0.corner_a  = newer_x;
                    prim0.corner_b  = v_x;
                    prim_count      = 2'd1;
                    // closing line back to the first vertex
                    if (set_last) begin
                        prim1.prim_kind = KIND_LINE;
                        prim1.corner_a  = v_x;
                        prim1.corner_b  = anchor_x;
                        prim_count      = 2'd2;
                    end
                end
            end
            MODE_LINE_STRIP: begin
                if (fill_reg != 2'd0) begin
                    prim0.prim_kind = KIND_LINE;
                    prim0.corner_a  = newer_x;
                    prim0.corner_b  = v_x;
                    prim_count      = 2'd1;
                end
            end
            MODE_TRIANGLES: begin
                if (phase_reg == 2'd2) begin
                    prim0.prim_kind = KIND_TRIANGLE;
                    prim0.corner_a  = older_x;
                    prim0.corner_b  = newer_x;
                    prim0.corner_c  = v_x;
                    prim_count      = 2'd1;
                end
            end
            MODE_TRIANGLE_STRIP: begin
                if (fill_reg >= 2'd2) begin
                    // odd positions swap winding
                    prim0.prim_kind = KIND_TRIANGLE;
                    prim0.corner_a  = older_x;
                    prim0.corner_b  = phase_reg[0] ? v_x : newer_x;
                    prim0.corner_c  = phase_reg[0] ? newer_x : v_x;
                    prim_count      = 2'd1;
                end
            end
            MODE_TRIANGLE_FAN, MODE_POLYGON: begin
                if (fill_reg >= 2'd2) begin
                    prim0.prim_kind = KIND_TRIANGLE;
                    prim0.corner_a  = anchor_x;
                    prim0.corner_b  = newer_x;
                    prim0.corner_c  = v_x;
                    prim_count      = 2'd1;
                end
            end
            MODE_QUADS: begin
                if (phase_reg == 2'd3) begin
                    prim0.prim_kind = KIND_TRIANGLE;
                    prim0.corner_a  = anchor_x;
                    prim0.corner_b  = older_x;
                    prim0.corner_c  = newer_x;
                    prim1.prim_kind = KIND_TRIANGLE;
                    prim1.corner_a  = anchor_x;
                    prim1.corner_b  = newer_x;
                    prim1.corner_c  = v_x;
                    prim_count      = 2'd2;
                end
            end
            MODE_QUAD_STRIP: begin
                if ((fill_reg == 2'd3) && phase_reg[0]) begin
                    prim0.prim_kind = KIND_TRIANGLE;
                    prim0.corner_a  = anchor_x;
                    prim0.corner_b  = older_x;
                    prim0.corner_c  = newer_x;
                    prim1.prim_kind = KIND_TRIANGLE;
                    prim1.corner_a  = older_x;
                    prim1.corner_b  = v_x;
                    prim1.corner_c  = newer_x;
                    prim_count      = 2'd2;
                end
            end
            default: begin
                prim_count = 2'd0;
            end
        endcase
        // mark the final primitive of this item
        prim0.run_last = (prim_count == 2'd1);
        prim1.run_last = (prim_count == 2'd2);
    end

    // history and counter update
    always_comb begin
        if (fill_reg == 2'd0) begin
            anchor_next = v;
        end else if (quad_mode) begin
            anchor_next = older_reg;
        end else begin
            anchor_next = anchor_reg;
        end
        if (set_last) begin
            phase_next = 2'd0;
            fill_next  = 2'd0;
        end else begin
            if (mode_reg == MODE_TRIANGLES) begin
                phase_next = (phase_reg >= 2'd2) ? 2'd0 : phase_reg + 2'd1;
            end else begin
                phase_next = phase_reg + 2'd1;
            end
            fill_next = (fill_reg == 2'd3) ? fill_reg : fill_reg + 2'd1;
        end
    end

    // mode register and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RESET;
            anchor_reg <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            phase_reg  <= '0;
            fill_reg   <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (item_acc) begin
                anchor_reg <= anchor_next;
                older_reg  <= newer_reg;
                newer_reg  <= v;
                phase_reg  <= phase_next;
                fill_reg   <= fill_next;
            end
        end
    end

endmodule

// File: src/pa_result_queue.sv
// ----------------------------------------------------------------------------
// pa_result_queue: three-entry result queue
// Takes zero, one or two primitives per cycle and hands them out one at a
// time on the output channel. Room is flagged while two entries are free.
// ----------------------------------------------------------------------------
module pa_result_queue
    import pa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_en,
    input  logic [1:0] push_count,
    input  prim_t     push0,
    input  prim_t     push1,
    input  logic      pop_ready,
    output logic      head_valid,
    output prim_t     head,
    output q_status_t status
);

    localparam int DEPTH = 3;

    prim_t      mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;
    logic [1:0] push_n;
    logic       pop;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign push_n     = push_en ? push_count : 2'd0;
    assign head_valid = (level_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign status.room  = (level_reg <= 2'd1);
    assign status.level = level_reg;

    // pointer and fill arithmetic
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == 2'd1) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end else if (push_n == 2'd2) begin
            wr_ptr_next = ptr_inc(ptr_inc(wr_ptr_reg));
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + push_n - {1'b0, pop};
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[ptr_inc(wr_ptr_reg)] <= push1;
        end
    end

endmodule

// File: src/primitive_assembly_core.sv
// ----------------------------------------------------------------------------
// primitive_assembly_core: GL primitive assembly
// Turns a stream of vertex indices into points, lines and triangles.
// ----------------------------------------------------------------------------
// Each item on the slave channel is one vertex index, tlast closing the
// primitive set. The mode register (GL numbering, 0 points up to 9 polygon,
// reset to triangles) selects how vertices are joined; codes above 9 emit
// nothing. An item is assembled in the cycle it is accepted; its primitives
// are registered in the result queue and sent on the master channel, tlast
// marking the last primitive of that item. One item is taken every cycle
// while each gives at most one primitive and the master side takes; an item
// giving two (quads, quad strip, the closing line of a line loop) holds off
// the next item, as the three-entry result queue takes items only while two
// entries are free. Only the low INDEX_WIDTH bits of an index are kept;
// corners are zero-extended. Write the mode only while no item is in flight.
module primitive_assembly_core
    import pa_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // mode register
    input  logic                 cfg_we,
    input  logic [MODE_W-1:0]    cfg_wdata,
    // vertex items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [FIELD_W-1:0]   s_tdata,   // [31:0] vertex_index
    input  logic                 s_tlast,   // set_last
    // primitive items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [3*FIELD_W-1:0] m_tdata,   // [31:0] corner_a, [63:32] corner_b,
                                            // [95:64] corner_c
    output logic [1:0]           m_tuser,   // prim_kind
    output logic                 m_tlast    // run_last
);

    logic      s_acc;
    logic      m_acc;
    logic [1:0] prim_count;
    prim_t     prim0, prim1, head;
    q_status_t q_stat;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = q_stat.room;

    // assembler
    pa_assemble #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_assemble (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_acc     (s_acc),
        .vertex_index (s_tdata),
        .set_last     (s_tlast),
        .prim_count   (prim_count),
        .prim0        (prim0),
        .prim1        (prim1)
    );

    // result queue
    pa_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (s_acc),
        .push_count (prim_count),
        .push0      (prim0),
        .push1      (prim1),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .status     (q_stat)
    );

    // output packing
    assign m_tdata = {head.corner_c, head.corner_b, head.corner_a};
    assign m_tuser = head.prim_kind;
    assign m_tlast = head.run_last;

    // only the final primitive of an item carries tlast
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (prim_count == 2'd2)) |-> (prim1.run_last && !prim0.run_last))
        else $error("double primitive item marks wrong last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (prim_count == 2'd1)) |-> prim0.run_last)
        else $error("single primitive item not marked last");

    // queue level follows pushes when nothing leaves
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !m_acc) |=>
            (q_stat.level == $past(q_stat.level) + $past(prim_count)))
        else $error("result queue lost or gained entries");

    // accepting is only possible with two free entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> (q_stat.level <= 2'd1))
        else $error("item accepted without queue room");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: primitive assembly core
// Feeds vertex index sets under every GL mode and checks each primitive
// against an in-bench assembler.
// ----------------------------------------------------------------------------
// Vertex items are sent in bursts with random gaps. The result side stalls on
// its own rotating pattern. Each accepted vertex is assembled here and the
// primitives it should give are queued. Every primitive the core delivers is
// compared field by field with the oldest queued one. The mode register is
// only rewritten once all queued primitives have arrived and the core has
// had time to settle, which includes changes in the middle of a set.
module testbench;
    import pa_pkg::*;

    localparam int IDX_W = INDEX_WIDTH_DEF;
    localparam logic [FIELD_W-1:0] IDX_MASK = FIELD_W'((64'd1 << IDX_W) - 1);
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1600;
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [MODE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [FIELD_W-1:0]   s_tdata = '0;    // [31:0] vertex_index
    logic                 s_tlast = 1'b0;  // set_last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [3*FIELD_W-1:0] m_tdata;         // [31:0] corner_a, [63:32] corner_b,
                                           // [95:64] corner_c
    logic [1:0]           m_tuser;         // prim_kind
    logic                 m_tlast;         // run_last

    // assembler state mirrored in the bench
    logic [MODE_W-1:0]  cur_mode = MODE_RESET;
    logic [FIELD_W-1:0] anchor_v = '0;
    logic [FIELD_W-1:0] older_v = '0;
    logic [FIELD_W-1:0] newer_v = '0;
    logic [1:0]         phase = '0;
    logic [1:0]         fill = '0;

    prim_t fresh_prims[$];
    prim_t prims_due[$];
    prim_t head_prim;

    int mismatches = 0;
    int items_sent = 0;
    int sets_closed = 0;
    int modes_written = 0;
    int prims_seen = 0;
    int burst_left = 0;
    int burst_gap = 0;
    int cycle_count = 0;

    always #6 aclk = ~aclk;

    primitive_assembly_core #(
        .INDEX_WIDTH(IDX_W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // generous overall limit
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic void add_prim(kind_t k, logic [FIELD_W-1:0] a,
                                     logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] c);
        prim_t p;
        p = '0;
        p.prim_kind = k;
        p.corner_a = a;
        p.corner_b = b;
        p.corner_c = c;
        fresh_prims = {fresh_prims, p};
    endfunction

    // primitives caused by one vertex, then history and counter update
    function automatic void assemble_vertex(logic [FIELD_W-1:0] idx, logic last);
        logic [FIELD_W-1:0] v;
        v = idx & IDX_MASK;
        fresh_prims.delete();
        case (cur_mode)
            MODE_POINTS: add_prim(KIND_POINT, v, '0, '0);
            MODE_LINES: begin
                if (phase[0]) add_prim(KIND_LINE, newer_v, v, '0);
            end
            MODE_LINE_LOOP: begin
                if (fill >= 1) begin
                    add_prim(KIND_LINE, newer_v, v, '0);
                    // closing line back to the first vertex
                    if (last) add_prim(KIND_LINE, v, anchor_v, '0);
                end
            end
            MODE_LINE_STRIP: begin
                if (fill >= 1) add_prim(KIND_LINE, newer_v, v, '0);
            end
            MODE_TRIANGLES: begin
                if (phase == 2) add_prim(KIND_TRIANGLE, older_v, newer_v, v);
            end
            MODE_TRIANGLE_STRIP: begin
                if (fill >= 2) begin
                    // odd positions swap winding
                    if (phase[0]) add_prim(KIND_TRIANGLE, older_v, v, newer_v);
                    else add_prim(KIND_TRIANGLE, older_v, newer_v, v);
                end
            end
            MODE_TRIANGLE_FAN, MODE_POLYGON: begin
                if (fill >= 2) add_prim(KIND_TRIANGLE, anchor_v, newer_v, v);
            end
            MODE_QUADS: begin
                if (phase == 3) begin
                    add_prim(KIND_TRIANGLE, anchor_v, older_v, newer_v);
                    add_prim(KIND_TRIANGLE, anchor_v, newer_v, v);
                end
            end
            MODE_QUAD_STRIP: begin
                if (fill >= 3 && phase[0]) begin
                    add_prim(KIND_TRIANGLE, anchor_v, older_v, newer_v);
                    add_prim(KIND_TRIANGLE, older_v, v, newer_v);
                end
            end
            default: ;
        endcase
        if (fresh_prims.size() > 0) fresh_prims[fresh_prims.size()-1].run_last = 1'b1;
        prims_due = {prims_due, fresh_prims};

        if (fill == 0) anchor_v = v;
        else if (cur_mode == MODE_QUADS || cur_mode == MODE_QUAD_STRIP) anchor_v = older_v;
        older_v = newer_v;
        newer_v = v;
        if (last) begin
            phase = '0;
            fill = '0;
        end else begin
            if (cur_mode == MODE_TRIANGLES) phase = (phase >= 2) ? 2'd0 : phase + 2'd1;
            else phase = phase + 2'd1;
            if (fill < 3) fill = fill + 2'd1;
        end
    endfunction

    // receiver stall pattern, rotating through four settings
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 300) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycle_count % 7) < 4);
        endcase
    end

    // primitive checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            prims_seen++;
            if (prims_due.size() == 0) begin
                report_mismatch($sformatf("unexpected primitive kind %0d a=%h b=%h c=%h",
                    m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]));
            end else begin
                head_prim = prims_due.pop_front();
                if (m_tuser !== head_prim.prim_kind)
                    report_mismatch($sformatf("prim_kind %0d, wanted %0d",
                        m_tuser, head_prim.prim_kind));
                if (m_tdata[FIELD_W-1:0] !== head_prim.corner_a)
                    report_mismatch($sformatf("corner_a %h, wanted %h",
                        m_tdata[FIELD_W-1:0], head_prim.corner_a));
                if (m_tdata[2*FIELD_W-1:FIELD_W] !== head_prim.corner_b)
                    report_mismatch($sformatf("corner_b %h, wanted %h",
                        m_tdata[2*FIELD_W-1:FIELD_W], head_prim.corner_b));
                if (m_tdata[3*FIELD_W-1:2*FIELD_W] !== head_prim.corner_c)
                    report_mismatch($sformatf("corner_c %h, wanted %h",
                        m_tdata[3*FIELD_W-1:2*FIELD_W], head_prim.corner_c));
                if (m_tlast !== head_prim.run_last)
                    report_mismatch($sformatf("run_last %b, wanted %b",
                        m_tlast, head_prim.run_last));
            end
        end
    end

    // send one vertex item, bursts separated by random gaps
    task automatic send_vertex(input logic [FIELD_W-1:0] idx, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            burst_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (burst_gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (burst_gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= idx;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        assemble_vertex(idx, last);
        items_sent++;
        if (last) sets_closed++;
    endtask

    // hold off until every queued primitive has come and the core is quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (prims_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_mode(input logic [MODE_W-1:0] m);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_mode = m;
        modes_written++;
    endtask

    function automatic logic [FIELD_W-1:0] rand_index();
        case ($urandom_range(0, 3))
            0: return FIELD_W'($urandom_range(0, 15));
            1: return ALL_ONES - FIELD_W'($urandom_range(0, 15));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // set length that completes whole primitives in the given mode, mostly
    function automatic int set_length(logic [MODE_W-1:0] m);
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, 12);
        case (m)
            MODE_LINES: return 2 * $urandom_range(1, 5);
            MODE_TRIANGLES: return 3 * $urandom_range(1, 4);
            MODE_QUADS: return 4 * $urandom_range(1, 3);
            MODE_QUAD_STRIP: return 2 * $urandom_range(1, 5) + 2;
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    // triangles straight out of reset, index extremes
    task automatic test_reset_mode();
        send_vertex('0, 1'b0);
        send_vertex(ALL_ONES, 1'b0);
        send_vertex(32'h0000_0001, 1'b1);
    endtask

    // one short set per mode but line loop and triangles, with an incomplete tail in lines mode
    task automatic test_every_mode();
        program_mode(MODE_POINTS);
        send_vertex(ALL_ONES, 1'b1);
        program_mode(MODE_LINES);
        send_vertex(32'h0000_0000, 1'b0);
        send_vertex(ALL_ONES, 1'b0);
        send_vertex(32'h5555_5555, 1'b1);
        program_mode(MODE_LINE_STRIP);
        send_vertex(32'hAAAA_AAAA, 1'b0);
        send_vertex(32'h5555_5555, 1'b1);
        program_mode(MODE_TRIANGLE_STRIP);
        send_vertex(32'd1, 1'b0);
        send_vertex(32'd2, 1'b0);
        send_vertex(32'd3, 1'b0);
        send_vertex(32'd4, 1'b1);
        program_mode(MODE_TRIANGLE_FAN);
        send_vertex(32'd10, 1'b0);
        send_vertex(32'd11, 1'b0);
        send_vertex(32'd12, 1'b1);
        program_mode(MODE_QUADS);
        send_vertex('0, 1'b0);
        send_vertex(ALL_ONES, 1'b0);
        send_vertex(32'd2, 1'b0);
        send_vertex(32'd3, 1'b1);
        program_mode(MODE_QUAD_STRIP);
        send_vertex(32'd4, 1'b0);
        send_vertex(32'd5, 1'b0);
        send_vertex(32'd6, 1'b0);
        send_vertex(32'd7, 1'b1);
        program_mode(MODE_POLYGON);
        send_vertex(ALL_ONES, 1'b0);
        send_vertex(32'd1, 1'b0);
        send_vertex(32'd2, 1'b1);
        // unused code: history moves on, nothing comes out
        program_mode(4'd15);
        send_vertex(32'd9, 1'b1);
    endtask

    // line loop of one vertex and of two vertices
    task automatic test_line_loop_edges();
        program_mode(MODE_LINE_LOOP);
        send_vertex(32'd7, 1'b1);
        send_vertex(ALL_ONES, 1'b0);
        send_vertex('0, 1'b1);
    endtask

    // mode changes inside an open set keep the counters
    task automatic test_mode_switch_in_set();
        program_mode(MODE_POINTS);
        repeat (3) send_vertex(rand_index(), 1'b0);
        // triangles phase of three wraps to zero without output
        program_mode(MODE_TRIANGLES);
        send_vertex(rand_index(), 1'b0);
        send_vertex(rand_index(), 1'b0);
        send_vertex(rand_index(), 1'b0);
        send_vertex(rand_index(), 1'b1);
        send_vertex(rand_index(), 1'b0);
        send_vertex(rand_index(), 1'b0);
        program_mode(MODE_QUADS);
        send_vertex(rand_index(), 1'b0);
        send_vertex(rand_index(), 1'b1);
    endtask

    // random modes and sets, now and then a mode change mid-set
    task automatic test_random_sets();
        int start_count;
        int n_sets;
        int len;
        int mid;
        int r;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 17);
            program_mode((r < 16) ? MODE_W'(r % 10) : MODE_W'($urandom_range(10, 15)));
            n_sets = $urandom_range(1, 5);
            for (int s = 0; s < n_sets; s++) begin
                len = set_length(cur_mode);
                mid = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
                for (int i = 0; i < len; i++) begin
                    if (mid > 0 && i == mid) program_mode(MODE_W'($urandom_range(0, 9)));
                    send_vertex(rand_index(), i == len - 1);
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_mode();
        test_every_mode();
        test_line_loop_edges();
        test_mode_switch_in_set();
        test_random_sets();
        wait_idle();
        $display("run covered %0d vertex items in %0d closed sets over %0d mode writes",
            items_sent, sets_closed, modes_written);
        $display("%0d primitives checked, %0d mismatches", prims_seen, mismatches);
        if (mismatches == 0 && prims_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
